// ----- hdl/gfg_pkg.sv -----
// ----------------------------------------------------------------------------
// gfg_pkg: shared types and constants of the grid field gather block
// Grid geometry, fixed point widths, control codes and the saturation helper.
// ----------------------------------------------------------------------------
package gfg_pkg;

  localparam int GRID_N  = 16;
  localparam int NCOMP   = 6;
  localparam int CELLS   = GRID_N * GRID_N * GRID_N;
  localparam int AW      = $clog2(CELLS);
  localparam int CW      = $clog2(GRID_N);
  localparam int GW      = CW + 16;
  localparam int FW      = 17;
  localparam int NCORNER = 8;
  localparam int CFG_AW  = 4;

  localparam logic [1:0] REG_INV_SPACING      = 2'd0;
  localparam logic [1:0] REG_CHARGE_OVER_MASS = 2'd1;
  localparam logic [1:0] REG_INV_LIGHT_SPEED  = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {LOP_NONE, LOP_X, LOP_Y, LOP_Z} lerp_op_e;

  typedef struct packed {
    logic     load_a;
    lerp_op_e op;
  } lane_ctrl_t;

  typedef enum logic [2:0] {ST_IDLE, ST_SCALE, ST_GATHER, ST_FORCE, ST_OUT} state_e;

  typedef enum logic [2:0] {
    FS_IDLE, FS_MUL_A, FS_MUL_B, FS_CROSS, FS_MUL_C, FS_SUM, FS_MUL_Q, FS_ACC
  } force_step_e;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  function automatic word_t sat32(input logic signed [65:0] v);
    word_t r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/gfg_ram.sv -----
// ----------------------------------------------------------------------------
// gfg_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/gfg_lane.sv -----
// ----------------------------------------------------------------------------
// gfg_lane: trilinear interpolation lane for one field component
// Takes the eight corners as they stream out of the ram and runs seven lerps
// through one two-stage multiply unit.
// ----------------------------------------------------------------------------
module gfg_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gfg_pkg::lane_ctrl_t   ctrl_i,
  input  logic [gfg_pkg::FW-1:0] f_i,
  input  gfg_pkg::word_t        rdata_i,
  output gfg_pkg::word_t        fld_o
);
  import gfg_pkg::*;

  word_t             a_q, base_q, fld_q, op_a, op_b, res;
  word_t             xs_q [4];
  word_t             ys_q [2];
  logic signed [50:0] prod_d, prod_q;
  logic signed [51:0] sum;
  lerp_op_e          dst_q;

  always_comb begin
    case (ctrl_i.op)
      LOP_Y: begin
        op_a = xs_q[0];
        op_b = xs_q[2];
      end
      LOP_Z: begin
        op_a = ys_q[0];
        op_b = ys_q[1];
      end
      default: begin
        op_a = a_q;
        op_b = rdata_i;
      end
    endcase
    prod_d = (33'(op_b) - 33'(op_a)) * $signed({1'b0, f_i});
  end

  // a*(1-f) + b*f rounded half up
  assign sum = (52'(base_q) <<< 16) + 52'(prod_q) + 52'sd32768;
  assign res = sum[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_q <= LOP_NONE;
    end else begin
      dst_q <= ctrl_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= op_a;
    prod_q <= prod_d;
    if (ctrl_i.load_a) begin
      a_q <= rdata_i;
    end
    if (dst_q == LOP_X) begin
      xs_q[0] <= xs_q[1];
      xs_q[1] <= xs_q[2];
      xs_q[2] <= xs_q[3];
      xs_q[3] <= res;
    end else if (ctrl_i.op == LOP_Y) begin
      // drop the front edge so the second y lerp sees its pair at the same taps
      xs_q[0] <= xs_q[1];
      xs_q[1] <= xs_q[2];
      xs_q[2] <= xs_q[3];
    end
    if (dst_q == LOP_Y) begin
      ys_q[0] <= ys_q[1];
      ys_q[1] <= res;
    end
    if (dst_q == LOP_Z) begin
      fld_q <= res;
    end
  end

  assign fld_o = fld_q;

endmodule

// ----- hdl/gfg_force.sv -----
// ----------------------------------------------------------------------------
// gfg_force: lorentz acceleration sequencer
// One shared 32x32 multiplier, seven steps per axis, three axes in turn.
// ----------------------------------------------------------------------------
module gfg_force (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  gfg_pkg::word_t fld_i [gfg_pkg::NCOMP],
  input  gfg_pkg::word_t vel_i [3],
  input  gfg_pkg::word_t qm_i,
  input  logic [30:0]    ils_i,
  output logic           done_o,
  output gfg_pkg::word_t acc_o [3]
);
  import gfg_pkg::*;

  force_step_e        step_q, step_d;
  logic [1:0]         axis_q, axis_d;
  word_t              va, ba, vc, bc, e, mul_a, mul_b, cross_q, sum_q;
  word_t              acc_q [3];
  logic signed [63:0] prod_q, p1_q, prod_sh;
  logic signed [64:0] diff, diff_sh;

  // operand pick: acc = qm * (E + ils * (v x B))
  always_comb begin
    case (axis_q)
      2'd1: begin
        va = vel_i[2]; ba = fld_i[3]; vc = vel_i[0]; bc = fld_i[5]; e = fld_i[1];
      end
      2'd2: begin
        va = vel_i[0]; ba = fld_i[4]; vc = vel_i[1]; bc = fld_i[3]; e = fld_i[2];
      end
      default: begin
        va = vel_i[1]; ba = fld_i[5]; vc = vel_i[2]; bc = fld_i[4]; e = fld_i[0];
      end
    endcase
  end

  always_comb begin
    case (step_q)
      FS_MUL_B: begin
        mul_a = vc;
        mul_b = bc;
      end
      FS_MUL_C: begin
        mul_a = cross_q;
        mul_b = $signed({1'b0, ils_i});
      end
      FS_MUL_Q: begin
        mul_a = sum_q;
        mul_b = qm_i;
      end
      default: begin
        mul_a = va;
        mul_b = ba;
      end
    endcase
  end

  assign prod_sh = prod_q >>> 16;
  assign diff    = 65'(p1_q) - 65'(prod_q);
  assign diff_sh = diff >>> 16;

  always_comb begin
    step_d = step_q;
    axis_d = axis_q;
    case (step_q)
      FS_IDLE: begin
        if (start_i) begin
          step_d = FS_MUL_A;
          axis_d = 2'd0;
        end
      end
      FS_MUL_A: step_d = FS_MUL_B;
      FS_MUL_B: step_d = FS_CROSS;
      FS_CROSS: step_d = FS_MUL_C;
      FS_MUL_C: step_d = FS_SUM;
      FS_SUM:   step_d = FS_MUL_Q;
      FS_MUL_Q: step_d = FS_ACC;
      FS_ACC: begin
        if (axis_q == 2'd2) begin
          step_d = FS_IDLE;
        end else begin
          step_d = FS_MUL_A;
          axis_d = axis_q + 2'd1;
        end
      end
      default: step_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= FS_IDLE;
      axis_q <= 2'd0;
    end else begin
      step_q <= step_d;
      axis_q <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (step_q == FS_MUL_B) begin
      p1_q <= prod_q;
    end
    if (step_q == FS_CROSS) begin
      cross_q <= sat32(66'(diff_sh));
    end
    if (step_q == FS_SUM) begin
      sum_q <= sat32(66'(e) + 66'(sat32(66'(prod_sh))));
    end
    if (step_q == FS_ACC) begin
      acc_q[axis_q] <= sat32(66'(prod_sh));
    end
  end

  assign done_o = (step_q == FS_ACC) && (axis_q == 2'd2);
  assign acc_o  = acc_q;

endmodule

// ----- hdl/grid_field_gather_lorentz_force.sv -----
// ----------------------------------------------------------------------------
// grid_field_gather_lorentz_force: field gather and lorentz acceleration
// Grid storage in six component rams, trilinear lanes and a force sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests. tuser selects the kind: a write word with a
//   component below six stores one field value into the grid in the cycle
//   it is accepted and returns nothing; a query word scales the position,
//   gathers the eight surrounding corners and returns one m_axis word with
//   the acceleration, the six interpolated field components and, in tuser,
//   the clamped-to-grid flag. A query passes through position scaling on one
//   multiplier, the eight corner reads (one ram read per cycle, all six
//   components in parallel) with seven lerps through each lane multiplier,
//   the force (seven steps per axis on one shared multiplier) and the load
//   into the output register.
//   Requests are taken one at a time; the next one is accepted as soon as the
//   result sits in the output register, even while the receiver stalls.
//   A further query finishing while the old result still waits holds until
//   that result is taken.
//   Reset sets the registers to 1.0 and empties the output; grid contents
//   are undefined until written. The user must write the registers over the
//   apb port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module grid_field_gather_lorentz_force (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // cell_index, component, write_value, pos_x, pos_y, pos_z, vel_x, vel_y,
  // vel_z, zero pad
  input  logic [239:0]               s_axis_tdata,
  // req_type
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // acc_x, acc_y, acc_z, field_ex, field_ey, field_ez, field_bx, field_by,
  // field_bz
  output logic [287:0]               m_axis_tdata,
  // outside_grid
  output logic                       m_axis_tuser,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gfg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import gfg_pkg::*;

  localparam int CNT_W       = 4;
  localparam int SCALE_LAST  = 3;
  localparam int GATHER_LAST = 14;
  localparam int CNT_Y0      = 10;
  localparam int CNT_Y1      = 11;
  localparam int CNT_Z       = 13;
  localparam logic signed [63:0] G_TOP = 64'((GRID_N - 1) * 65536);
  localparam logic [CW-1:0]      C_MAX = CW'(GRID_N - 2);

  // config registers
  logic [30:0] inv_spacing_q, inv_light_speed_q;
  word_t       charge_over_mass_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_spacing_q      <= 31'd65536;
      charge_over_mass_q <= 32'sd65536;
      inv_light_speed_q  <= 31'd65536;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_INV_SPACING:      inv_spacing_q      <= pwdata[30:0];
        REG_CHARGE_OVER_MASS: charge_over_mass_q <= pwdata;
        REG_INV_LIGHT_SPEED:  inv_light_speed_q  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INV_SPACING:      prdata = {1'b0, inv_spacing_q};
      REG_CHARGE_OVER_MASS: prdata = charge_over_mass_q;
      REG_INV_LIGHT_SPEED:  prdata = {1'b0, inv_light_speed_q};
      default:              prdata = 32'd0;
    endcase
  end

  // input word fields
  logic [11:0] in_cell;
  logic [2:0]  in_comp;
  word_t       in_value;
  word_t       in_pos [3];
  word_t       in_vel [3];

  assign in_cell   = s_axis_tdata[11:0];
  assign in_comp   = s_axis_tdata[14:12];
  assign in_value  = s_axis_tdata[46:15];
  assign in_pos[0] = s_axis_tdata[78:47];
  assign in_pos[1] = s_axis_tdata[110:79];
  assign in_pos[2] = s_axis_tdata[142:111];
  assign in_vel[0] = s_axis_tdata[174:143];
  assign in_vel[1] = s_axis_tdata[206:175];
  assign in_vel[2] = s_axis_tdata[238:207];

  // control
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, rcnt;
  logic             s_acc, q_acc, wr_en, out_load, m_valid_q;
  logic             force_start, force_done;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign q_acc         = s_acc && (s_axis_tuser == REQ_QUERY);
  assign wr_en         = s_acc && (s_axis_tuser == REQ_WRITE) && (int'(in_cell) < CELLS)
                         && (int'(in_comp) < NCOMP);
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign force_start   = (state_q == ST_GATHER) && (cnt_q == CNT_W'(GATHER_LAST));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (q_acc) begin
          state_d = ST_SCALE;
          cnt_d   = '0;
        end
      end
      ST_SCALE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SCALE_LAST)) begin
          state_d = ST_GATHER;
          cnt_d   = '0;
        end
      end
      ST_GATHER: begin
        cnt_d = cnt_q + 1'b1;
        if (force_start) begin
          state_d = ST_FORCE;
        end
      end
      ST_FORCE: begin
        if (force_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // position scaling, one axis per cycle
  word_t              pos_q [3];
  word_t              vel_q [3];
  word_t              pos_sel;
  logic signed [63:0] sprod_q, g;
  logic [GW-1:0]      gc;
  logic [CW-1:0]      gh, cell_new;
  logic [CW-1:0]      cell_q [3];
  logic [FW-1:0]      frac_q [3];
  logic [1:0]         axis;
  logic               clamp, outside_q;

  always_comb begin
    case (cnt_q[1:0])
      2'd1:    pos_sel = pos_q[1];
      2'd2:    pos_sel = pos_q[2];
      default: pos_sel = pos_q[0];
    endcase
  end

  assign g     = sprod_q >>> 16;
  assign clamp = (g < 64'sd0) || (g > G_TOP);
  assign gc    = (g < 64'sd0) ? '0 : ((g > G_TOP) ? G_TOP[GW-1:0] : g[GW-1:0]);
  assign gh    = gc[GW-1:16];
  assign cell_new = (gh > C_MAX) ? C_MAX : gh;
  assign axis  = 2'(cnt_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (q_acc) begin
      pos_q     <= in_pos;
      vel_q     <= in_vel;
      outside_q <= 1'b0;
    end
    sprod_q <= pos_sel * $signed({1'b0, inv_spacing_q});
    if ((state_q == ST_SCALE) && (cnt_q != '0)) begin
      cell_q[axis] <= cell_new;
      frac_q[axis] <= FW'(gc - {cell_new, 16'h0000});
      if (clamp) begin
        outside_q <= 1'b1;
      end
    end
  end

  // corner reads: bit 0 steps x, bit 1 steps z, bit 2 steps y
  logic [2:0]  corner;
  logic [CW:0] ii, jj, kk;
  logic [AW-1:0] raddr;
  logic        rd_en;
  lane_ctrl_t  lane_ctrl;
  logic [FW-1:0] lane_f;

  assign corner = cnt_q[2:0];
  assign rd_en  = (state_q == ST_GATHER) && (int'(cnt_q) < NCORNER);
  assign ii     = {1'b0, cell_q[0]} + (CW+1)'(corner[0]);
  assign jj     = {1'b0, cell_q[1]} + (CW+1)'(corner[2]);
  assign kk     = {1'b0, cell_q[2]} + (CW+1)'(corner[1]);
  assign raddr  = AW'(int'(ii) * GRID_N * GRID_N + int'(jj) * GRID_N + int'(kk));
  assign rcnt   = cnt_q - 1'b1;

  always_comb begin
    lane_ctrl.load_a = 1'b0;
    lane_ctrl.op     = LOP_NONE;
    lane_f           = frac_q[0];
    if (state_q == ST_GATHER) begin
      if ((cnt_q != '0) && (int'(cnt_q) <= NCORNER)) begin
        // x pairs come out back to back: first corner parks, second lerps
        if (rcnt[0]) begin
          lane_ctrl.op = LOP_X;
        end else begin
          lane_ctrl.load_a = 1'b1;
        end
      end else if ((cnt_q == CNT_W'(CNT_Y0)) || (cnt_q == CNT_W'(CNT_Y1))) begin
        lane_ctrl.op = LOP_Y;
        lane_f       = frac_q[1];
      end else if (cnt_q == CNT_W'(CNT_Z)) begin
        lane_ctrl.op = LOP_Z;
        lane_f       = frac_q[2];
      end
    end
  end

  word_t rdata [NCOMP];
  word_t fld   [NCOMP];

  for (genvar c = 0; c < NCOMP; c++) begin : g_comp
    gfg_ram #(
      .WIDTH (32),
      .DEPTH (CELLS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en && (in_comp == 3'(c))),
      .waddr_i (AW'(in_cell)),
      .wdata_i (in_value),
      .re_i    (rd_en),
      .raddr_i (raddr),
      .rdata_o (rdata[c])
    );

    gfg_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .f_i     (lane_f),
      .rdata_i (rdata[c]),
      .fld_o   (fld[c])
    );
  end

  word_t acc [3];

  gfg_force u_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (force_start),
    .fld_i   (fld),
    .vel_i   (vel_q),
    .qm_i    (charge_over_mass_q),
    .ils_i   (inv_light_speed_q),
    .done_o  (force_done),
    .acc_o   (acc)
  );

  // output register
  logic [287:0] m_data_q;
  logic         m_user_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {fld[5], fld[4], fld[3], fld[2], fld[1], fld[0], acc[2], acc[1], acc[0]};
      m_user_q <= outside_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ----- test/grid_field_gather_lorentz_force_checker.sv -----
// ----------------------------------------------------------------------------
// grid_field_gather_lorentz_force_checker: lorentz force result scoreboard
// Watches the request, result and register channels, keeps a shadow of the
// field grid and registers, predicts each query result and compares it.
// ----------------------------------------------------------------------------
module grid_field_gather_lorentz_force_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [239:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [287:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import gfg_pkg::*;

  typedef struct {
    logic [287:0] data;
    logic         outside;
  } force_result_t;

  logic [31:0]   grid_shadow [NCOMP*CELLS];
  longint        spacing_q, qm_q, inv_c_q;
  force_result_t expected_forces[$];

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mix(longint a, longint b, longint f);
    return fl16(a * (65536 - f) + b * f + 32768);
  endfunction

  function automatic longint corner(int c, int i, int j, int k);
    return longint'(signed'(grid_shadow[c*CELLS + (i*GRID_N + j)*GRID_N + k]));
  endfunction

  // exact floor((a*b - c*d)/2^16) via 128-bit intermediate, saturated to 32 bits
  function automatic longint cross_term(longint a, longint b, longint c, longint d);
    logic signed [127:0] p;
    p = (128'(signed'(a)) * 128'(signed'(b)) - 128'(signed'(c)) * 128'(signed'(d))) >>> 16;
    if (p > 128'sd2147483647) return 64'sd2147483647;
    if (p < -128'sd2147483648) return -64'sd2147483648;
    return longint'(p);
  endfunction

  function automatic longint accel(longint e, longint cr);
    longint s;
    s = sat(e + sat(fl16(cr * inv_c_q)));
    return sat(fl16(s * qm_q));
  endfunction

  function automatic force_result_t predict_force(logic [239:0] d);
    force_result_t r;
    longint g, top, cidx[3], frac[3], fld[6], v[3], a[3];
    longint c00, c01, c10, c11, c0, c1;
    logic out;
    out = 0;
    top = longint'(GRID_N - 1) * 65536;
    for (int ax = 0; ax < 3; ax++) begin
      g = fl16(longint'(signed'(d[47+32*ax +: 32])) * spacing_q);
      if (g < 0) begin g = 0; out = 1; end
      if (g > top) begin g = top; out = 1; end
      cidx[ax] = g >>> 16;
      if (cidx[ax] > GRID_N - 2) cidx[ax] = GRID_N - 2;
      frac[ax] = g - cidx[ax] * 65536;
      v[ax] = longint'(signed'(d[143+32*ax +: 32]));
    end
    for (int c = 0; c < 6; c++) begin
      c00 = mix(corner(c, cidx[0], cidx[1], cidx[2]),
                corner(c, cidx[0]+1, cidx[1], cidx[2]), frac[0]);
      c01 = mix(corner(c, cidx[0], cidx[1], cidx[2]+1),
                corner(c, cidx[0]+1, cidx[1], cidx[2]+1), frac[0]);
      c10 = mix(corner(c, cidx[0], cidx[1]+1, cidx[2]),
                corner(c, cidx[0]+1, cidx[1]+1, cidx[2]), frac[0]);
      c11 = mix(corner(c, cidx[0], cidx[1]+1, cidx[2]+1),
                corner(c, cidx[0]+1, cidx[1]+1, cidx[2]+1), frac[0]);
      c0 = mix(c00, c10, frac[1]);
      c1 = mix(c01, c11, frac[1]);
      fld[c] = mix(c0, c1, frac[2]);
    end
    a[0] = accel(fld[0], cross_term(v[1], fld[5], v[2], fld[4]));
    a[1] = accel(fld[1], cross_term(v[2], fld[3], v[0], fld[5]));
    a[2] = accel(fld[2], cross_term(v[0], fld[4], v[1], fld[3]));
    for (int n = 0; n < 3; n++) r.data[32*n +: 32] = a[n][31:0];
    for (int n = 0; n < 6; n++) r.data[96+32*n +: 32] = fld[n][31:0];
    r.outside = out;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    force_result_t want;
    if (!rst_ni) begin
      spacing_q = 65536;
      qm_q = 65536;
      inv_c_q = 65536;
      fail_count = 0;
      expected_forces.delete();
      pending_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INV_SPACING:      spacing_q = longint'(pwdata[30:0]);
          REG_CHARGE_OVER_MASS: qm_q = longint'(signed'(pwdata));
          REG_INV_LIGHT_SPEED:  inv_c_q = longint'(pwdata[30:0]);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_forces.size() == 0) begin
          fail_count++;
          $display("%t unexpected result word %h", $realtime, m_axis_tdata);
        end else begin
          want = expected_forces.pop_front();
          for (int n = 0; n < 9; n++)
            if (m_axis_tdata[32*n +: 32] !== want.data[32*n +: 32]) begin
              fail_count++;
              $display("%t field %0d expected %h actual %h", $realtime, n,
                       want.data[32*n +: 32], m_axis_tdata[32*n +: 32]);
            end
          if (m_axis_tuser !== want.outside) begin
            fail_count++;
            $display("%t outside flag expected %b actual %b", $realtime,
                     want.outside, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == REQ_QUERY) begin
          expected_forces.push_back(predict_force(s_axis_tdata));
        end else if (s_axis_tdata[11:0] < CELLS && s_axis_tdata[14:12] < NCOMP) begin
          grid_shadow[s_axis_tdata[14:12]*CELLS + s_axis_tdata[11:0]] = s_axis_tdata[46:15];
        end
      end
      pending_count = expected_forces.size();
    end
  end

endmodule

// ----- test/grid_field_gather_lorentz_force_test.sv -----
// ----------------------------------------------------------------------------
// grid_field_gather_lorentz_force_test: testbench top
// Fills the grid points whose coordinates all lie near the low and high edges,
// then sends directed and random queries and writes through several register
// settings with random gaps and back pressure.
// ----------------------------------------------------------------------------
module grid_field_gather_lorentz_force_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gfg_pkg::*;

  // coordinates per axis that get filled: 0, 1, 2 and the top two
  localparam int FILL_N = 5;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [239:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [287:0] m_axis_tdata;
  logic         psel, penable, pwrite, pready;
  logic [3:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           fail_count, pending_count;
  bit           hold_off_req;
  longint       spacing_tb;

  grid_field_gather_lorentz_force i_dut (.*);

  grid_field_gather_lorentz_force_checker i_checker (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int fill_coord(int n);
    return (n < 3) ? n : GRID_N - FILL_N + n;
  endfunction

  // true when the cell of this position has both its corners filled
  function automatic bit axis_ok(logic [31:0] p);
    longint g, c, top;
    top = longint'(GRID_N - 1) * 65536;
    g = (longint'(signed'(p)) * spacing_tb) >>> 16;
    if (g < 0) g = 0;
    if (g > top) g = top;
    c = g >>> 16;
    if (c > GRID_N - 2) c = GRID_N - 2;
    return (c <= 1) || (c == GRID_N - 2);
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial begin
    int n;
    bit held;
    m_axis_tready = 1'b0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held) begin
        m_axis_tready = 1'b0;
        for (n = 0; n < 400; n++) @(negedge clk_i);
        held = 1;
      end
      m_axis_tready = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 60) == 0) begin
        m_axis_tready = 1'b0;
        n = $urandom_range(10, 80);
        repeat (n) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_word(input logic kind, input logic [239:0] d);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_cell(input int cell_idx, input int comp, input logic [31:0] v);
    logic [239:0] d;
    d = '0;
    d[11:0] = cell_idx[11:0];
    d[14:12] = comp[2:0];
    d[46:15] = v;
    send_word(REQ_WRITE, d);
  endtask

  task automatic query(input logic [31:0] px, py, pz, vx, vy, vz);
    logic [239:0] d;
    d = 240'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom()});
    d[239:239] = 1'b0;
    d[239:47] = {1'b0, vz, vy, vx, pz, py, px};
    send_word(REQ_QUERY, d);
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] v);
    if (idx == REG_INV_SPACING) begin
      spacing_tb = longint'(v[30:0]);
    end
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return -$urandom_range(1, 32'h00100000);
      2: return 32'h7fffffff;
      3: return 32'h80000000;
      default: return $urandom_range(0, 32'h00100000);
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
  endfunction

  task automatic random_item();
    logic [31:0] px, py, pz;
    if ($urandom_range(0, 3) == 0) begin
      // includes out-of-range components, which are dropped
      write_cell($urandom_range(0, 4095), $urandom_range(0, 7), rand_field());
    end else begin
      do begin
        px = rand_pos();
        py = rand_pos();
        pz = rand_pos();
      end while (!(axis_ok(px) && axis_ok(py) && axis_ok(pz)));
      query(px, py, pz, rand_vel(), rand_vel(), rand_vel());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = REQ_WRITE;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_off_req = 0;
    spacing_tb = 65536;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // edge points written once; queries only use cells whose corners lie there
    for (int c = 0; c < NCOMP; c++)
      for (int a = 0; a < FILL_N; a++)
        for (int b = 0; b < FILL_N; b++)
          for (int e = 0; e < FILL_N; e++)
            write_cell((fill_coord(a) * GRID_N + fill_coord(b)) * GRID_N + fill_coord(e),
                       c, rand_field());

    // directed: extremes, edges, clamps, ignored writes
    query(32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h0);
    query(32'h000f0000, 32'h000f0000, 32'h000f0000, 32'h80000000, 32'h7fffffff, 32'h1);
    query(32'h000e8000, 32'h00008000, 32'h0001ffff, 32'hffffffff, 32'h00010000, 32'h0);
    query(32'h7fffffff, 32'h80000000, 32'h00018000, 32'h00010000, 32'h0, 32'h0);
    query(32'hffffffff, 32'h00010000, 32'h000fffff, 32'h0, 32'h0, 32'h7fffffff);
    write_cell(0, 0, 32'h7fffffff);
    write_cell(4095, 5, 32'h80000000);
    write_cell(1, 6, 32'h12345678);
    write_cell(2, 7, 32'hffffffff);
    write_cell(0, 3, 32'h80000000);
    write_cell(0, 4, 32'h7fffffff);
    query(32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    query(32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h80000000);
    query(32'h000f0000, 32'h000f0000, 32'h000f0000, 32'h7fffffff, 32'h7fffffff, 32'h1);

    // pause until every result is in, then hold the receiver off a long time
    drain();
    hold_off_req = 1;
    for (int n = 0; n < 12; n++) random_item();
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          set_reg(REG_INV_SPACING, 32'h7fffffff);
          set_reg(REG_CHARGE_OVER_MASS, 32'h80000000);
          set_reg(REG_INV_LIGHT_SPEED, 32'h7fffffff);
        end
        1: begin
          set_reg(REG_INV_SPACING, 32'h0);
          set_reg(REG_CHARGE_OVER_MASS, 32'h7fffffff);
          set_reg(REG_INV_LIGHT_SPEED, 32'h0);
        end
        2: begin
          set_reg(REG_INV_SPACING, 32'h00008000);
          set_reg(REG_CHARGE_OVER_MASS, 32'hffff0000);
          set_reg(REG_INV_LIGHT_SPEED, 32'h00000100);
        end
        3: begin
          set_reg(REG_INV_SPACING, 32'h00020000);
          set_reg(REG_CHARGE_OVER_MASS, $urandom());
          set_reg(REG_INV_LIGHT_SPEED, $urandom_range(0, 32'h7fffffff));
        end
        4: begin
          set_reg(REG_INV_SPACING, $urandom_range(0, 32'h00040000));
          set_reg(REG_CHARGE_OVER_MASS, 32'h0);
          set_reg(REG_INV_LIGHT_SPEED, 32'h80000000);
        end
        default: begin
          set_reg(REG_INV_SPACING, 32'h00010000);
          set_reg(REG_CHARGE_OVER_MASS, 32'h00010000);
          set_reg(REG_INV_LIGHT_SPEED, 32'h00010000);
        end
      endcase
      for (int n = 0; n < 196; n++) random_item();
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("grid_field_gather_lorentz_force verification clean");
    end else begin
      $display("grid_field_gather_lorentz_force verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("grid_field_gather_lorentz_force verification failed");
    $finish;
  end

endmodule
